>>> rtl/core/cfd_pkg.sv
// ----------------------------------------------------------------------------
// cfd_pkg
// Types and constants shared by the COBS frame decoder modules.
// ----------------------------------------------------------------------------
package cfd_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    // Frame status codes as they appear on the output
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_TRUNC = 2'd2,
        ST_LONG  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_DROP  = 2'd1,
        CMD_DELIM = 2'd2
    } t_cmd_kind;

    // One request from the front to the back
    typedef struct packed {
        t_cmd_kind  kind;
        t_status    status;
        logic [7:0] data;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

>>> rtl/core/cobs_frame_decoder.sv
// ----------------------------------------------------------------------------
// cobs_frame_decoder
// COBS frame decoder: one encoded byte in, decoded bytes out with frame status.
// ----------------------------------------------------------------------------
// Throughput: one encoded byte per cycle, sustained, with the output ready.
// Ordering: the request from an accepted byte is written into the queue, then popped
//   into the output register; a four-entry request queue absorbs output stalls.
// Reset: synchronous active low; clears frame state, queue and output valid.
// ----------------------------------------------------------------------------
module cobs_frame_decoder #(
    parameter int MAX_FRAME = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] rx_byte
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic       o_m_tlast,   // last_of_frame
    output logic [1:0] o_m_tuser    // [1:0] frame_status
);
    import cfd_pkg::*;

    logic    w_push;
    logic    w_pop;
    t_cmd    w_cmd;
    t_cmd    w_head;
    t_q_stat w_q_stat;

    cfd_front #(
        .MAX_FRAME (MAX_FRAME)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_q_stat   (w_q_stat),
        .o_push     (w_push),
        .o_cmd      (w_cmd)
    );

    cfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    cfd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .i_q_stat   (w_q_stat),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

>>> rtl/core/cfd_front.sv
// ----------------------------------------------------------------------------
// cfd_front
// Accepts encoded bytes, tracks block and frame state, and issues requests.
// ----------------------------------------------------------------------------
module cfd_front #(
    parameter int MAX_FRAME = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [7:0]    i_s_tdata,
    input  cfd_pkg::t_q_stat i_q_stat,
    output logic          o_push,
    output cfd_pkg::t_cmd o_cmd
);
    import cfd_pkg::*;

    localparam int CW = $clog2(MAX_FRAME + 1);

    logic [7:0]    r_rem, n_rem;
    logic          r_started, n_started;
    logic          r_zero_owed, n_zero_owed;
    logic [CW-1:0] r_count, n_count;
    logic          r_overlong, n_overlong;
    logic          w_acc;

    assign o_s_tready = !i_q_stat.full;
    assign w_acc      = i_s_tvalid && o_s_tready;

    always_comb begin
        n_rem       = r_rem;
        n_started   = r_started;
        n_zero_owed = r_zero_owed;
        n_count     = r_count;
        n_overlong  = r_overlong;
        o_push      = 1'b0;
        o_cmd.kind   = CMD_PUSH;
        o_cmd.status = ST_OK;
        o_cmd.data   = i_s_tdata;
        if (w_acc) begin
            if (i_s_tdata == 8'd0) begin
                // ST_OK here leaves ok versus empty to the back
                o_push    = 1'b1;
                o_cmd.kind = CMD_DELIM;
                o_cmd.data = 8'd0;
                if (r_overlong) begin
                    o_cmd.status = ST_LONG;
                end else if (r_rem != 8'd0) begin
                    o_cmd.status = ST_TRUNC;
                end
                n_rem       = 8'd0;
                n_started   = 1'b0;
                n_zero_owed = 1'b0;
                n_count     = '0;
                n_overlong  = 1'b0;
            end else begin
                n_started = 1'b1;
                if (r_overlong) begin
                    // ignore rest of an over-long frame
                end else if (r_count >= CW'(MAX_FRAME - 1)) begin
                    n_overlong = 1'b1;
                    o_push     = 1'b1;
                    o_cmd.kind = CMD_DROP;
                end else begin
                    n_count = r_count + 1'b1;
                    if (r_rem == 8'd0) begin
                        // code byte: release the implied zero of the prior block
                        o_push      = r_zero_owed;
                        o_cmd.data  = 8'd0;
                        n_rem       = i_s_tdata - 8'd1;
                        n_zero_owed = (i_s_tdata == 8'd1);
                    end else begin
                        o_push      = 1'b1;
                        n_rem       = r_rem - 8'd1;
                        n_zero_owed = (r_rem == 8'd1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem       <= 8'd0;
            r_started   <= 1'b0;
            r_zero_owed <= 1'b0;
            r_count     <= '0;
            r_overlong  <= 1'b0;
        end else begin
            r_rem       <= n_rem;
            r_started   <= n_started;
            r_zero_owed <= n_zero_owed;
            r_count     <= n_count;
            r_overlong  <= n_overlong;
        end
    end

    a_overlong_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_overlong |-> r_started)
        else $error("overlong flag set outside a frame");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_FRAME - 1))
        else $error("encoded count beyond frame limit");

    a_rem_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rem != 8'd0) |-> r_started)
        else $error("block open outside a frame");

endmodule

>>> rtl/core/cfd_queue.sv
// ----------------------------------------------------------------------------
// cfd_queue
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
module cfd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  cfd_pkg::t_cmd     i_cmd,
    input  logic              i_pop,
    output cfd_pkg::t_cmd     o_head,
    output cfd_pkg::t_q_stat  o_stat
);
    import cfd_pkg::*;

    t_cmd           r_mem [QDEPTH];
    logic [QAW-1:0] r_wptr, r_rptr;
    logic [QAW:0]   r_cnt, n_cnt;

    assign o_head       = r_mem[r_rptr];
    assign o_stat.full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("pop from empty queue");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wptr - r_rptr) == r_cnt[QAW-1:0])
        else $error("queue pointers disagree with count");

endmodule

>>> rtl/core/cfd_back.sv
// ----------------------------------------------------------------------------
// cfd_back
// Holds back one decoded byte, resolves frame status, drives the output stage.
// ----------------------------------------------------------------------------
module cfd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cfd_pkg::t_cmd    i_head,
    input  cfd_pkg::t_q_stat i_q_stat,
    output logic             o_pop,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [7:0]       o_m_tdata,
    output logic             o_m_tlast,
    output logic [1:0]       o_m_tuser
);
    import cfd_pkg::*;

    logic [7:0] r_held, n_held;
    logic       r_held_v, n_held_v;
    logic       r_out_v;
    logic [7:0] r_out_byte, n_out_byte;
    logic       r_out_last, n_out_last;
    t_status    r_out_st, n_out_st;
    logic       w_needs_out;
    logic       w_out_free;

    assign w_out_free = !r_out_v || i_m_tready;

    always_comb begin
        n_held      = r_held;
        n_held_v    = r_held_v;
        n_out_byte  = r_held;
        n_out_last  = 1'b0;
        n_out_st    = ST_OK;
        w_needs_out = 1'b0;
        case (i_head.kind)
            CMD_PUSH: begin
                w_needs_out = r_held_v;
                n_held      = i_head.data;
                n_held_v    = 1'b1;
            end
            CMD_DROP: begin
                n_held_v = 1'b0;
            end
            CMD_DELIM: begin
                w_needs_out = 1'b1;
                n_out_last  = 1'b1;
                n_held_v    = 1'b0;
                if (i_head.status != ST_OK) begin
                    n_out_st   = i_head.status;
                    n_out_byte = 8'd0;
                end else if (!r_held_v) begin
                    n_out_st   = ST_EMPTY;
                    n_out_byte = 8'd0;
                end
            end
            default: begin
                w_needs_out = 1'b0;
            end
        endcase
        o_pop = !i_q_stat.empty && (!w_needs_out || w_out_free);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_held_v <= n_held_v;
            end
            if (o_pop && w_needs_out) begin
                r_out_v <= 1'b1;
            end else if (i_m_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_held <= n_held;
        end
        if (o_pop && w_needs_out) begin
            r_out_byte <= n_out_byte;
            r_out_last <= n_out_last;
            r_out_st   <= n_out_st;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out_byte;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_st;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out_st != ST_OK) |-> (r_out_byte == 8'd0 && r_out_last))
        else $error("error result carries data or lacks last");

    a_mid_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !r_out_last) |-> (r_out_st == ST_OK))
        else $error("nonzero status before frame end");

    a_no_clobber: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !i_m_tready) |-> !(o_pop && w_needs_out))
        else $error("pending result overwritten");

    a_delim_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_head.kind == CMD_DELIM) |=> !r_held_v)
        else $error("held byte survives a delimiter");

endmodule
